### design/i2cms_pkg.sv
// Shared codes, widths and control types for the I2C master bit sequencer.
// No dependencies; every other file imports this package.
package i2cms_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_CNT_W     = $clog2(BITS_PER_BYTE);

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WBYTE = 3'd2;
  localparam logic [2:0] CMD_RBYTE = 3'd3;
  localparam logic [2:0] CMD_WACK  = 3'd4;
  localparam logic [2:0] CMD_RACK  = 3'd5;

  localparam logic [2:0] ACT_SDA0   = 3'd0;
  localparam logic [2:0] ACT_SDA1   = 3'd1;
  localparam logic [2:0] ACT_SDA_TX = 3'd2;
  localparam logic [2:0] ACT_SCL0   = 3'd3;
  localparam logic [2:0] ACT_SCL1   = 3'd4;
  localparam logic [2:0] ACT_SAMPLE = 3'd5;

  typedef logic [2:0]               cmd_t;
  typedef logic [2:0]               act_t;
  typedef logic [BITS_PER_BYTE-1:0] byte_t;

  typedef struct packed {
    act_t act;
    logic last;
    logic rd_byte;
    logic rd_ack;
    logic tx_shift;
    logic rx_shift;
  } phase_t;

endpackage

### design/i2cms_if.sv
// Valid/ready channel interfaces for command items and bus phase items.
// Depends on i2cms_pkg.
interface i2cms_cmd_if;
  import i2cms_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  command;
  byte_t data_byte;
  logic  ack_value;
  byte_t bus_bits;

  modport source (output valid, command, data_byte, ack_value, bus_bits, input ready);
  modport sink   (input valid, command, data_byte, ack_value, bus_bits, output ready);
endinterface

interface i2cms_phase_if;
  import i2cms_pkg::*;
  logic  valid;
  logic  ready;
  logic  scl;
  logic  sda;
  byte_t read_byte;
  logic  ack_seen;
  logic  last;

  modport source (output valid, scl, sda, read_byte, ack_seen, last, input ready);
  modport sink   (input valid, scl, sda, read_byte, ack_seen, last, output ready);
endinterface

### design/i2cms_seq.sv
// Phase sequencer: walks the phases of one command with a sub-phase and bit counter.
// Depends on i2cms_pkg.
module i2cms_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  i2cms_pkg::cmd_t   cmd_in,
  input  logic              step,
  output logic              busy,
  output i2cms_pkg::phase_t phase
);
  import i2cms_pkg::*;

  logic                 busy_r, busy_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [1:0]           sub_r, sub_nxt;
  logic [BIT_CNT_W-1:0] bit_r, bit_nxt;
  logic                 pre_r, pre_nxt;
  logic [1:0]           sub_end;
  logic [BIT_CNT_W-1:0] bit_lim;
  logic                 run_end;

  always_comb begin
    sub_end = (cmd_r == CMD_START) ? 2'd3 : 2'd2;
    bit_lim = (cmd_r == CMD_WBYTE || cmd_r == CMD_RBYTE) ?
              BIT_CNT_W'(BITS_PER_BYTE - 1) : '0;
    run_end = !pre_r && (sub_r == sub_end) && (bit_r == bit_lim);
  end

  always_comb begin
    phase = '0;
    phase.act  = ACT_SAMPLE;
    phase.last = run_end;
    unique case (cmd_r) inside
      CMD_START: begin
        unique case (sub_r)
          2'd0:    phase.act = ACT_SDA1;
          2'd1:    phase.act = ACT_SCL1;
          2'd2:    phase.act = ACT_SDA0;
          default: phase.act = ACT_SCL0;
        endcase
      end
      CMD_STOP: begin
        unique case (sub_r)
          2'd0:    phase.act = ACT_SDA0;
          2'd1:    phase.act = ACT_SCL1;
          default: phase.act = ACT_SDA1;
        endcase
      end
      CMD_WBYTE, CMD_WACK: begin
        unique case (sub_r)
          2'd0:    phase.act = ACT_SDA_TX;
          2'd1:    phase.act = ACT_SCL1;
          default: phase.act = ACT_SCL0;
        endcase
        phase.tx_shift = (sub_r == 2'd2);
      end
      CMD_RBYTE, CMD_RACK: begin
        if (pre_r) begin
          phase.act = ACT_SDA1;
        end else begin
          unique case (sub_r)
            2'd0:    phase.act = ACT_SCL1;
            2'd1:    phase.act = ACT_SAMPLE;
            default: phase.act = ACT_SCL0;
          endcase
          phase.rx_shift = (sub_r == 2'd1);
        end
        phase.rd_byte = run_end && (cmd_r == CMD_RBYTE);
        phase.rd_ack  = run_end && (cmd_r == CMD_RACK);
      end
      default: phase.act = ACT_SAMPLE;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    cmd_nxt  = cmd_r;
    sub_nxt  = sub_r;
    bit_nxt  = bit_r;
    pre_nxt  = pre_r;
    if (load) begin
      cmd_nxt  = cmd_in;
      sub_nxt  = '0;
      bit_nxt  = '0;
      pre_nxt  = (cmd_in == CMD_RBYTE) || (cmd_in == CMD_RACK);
      busy_nxt = (cmd_in <= CMD_RACK);
    end else if (step && busy_r) begin
      if (run_end) begin
        busy_nxt = 1'b0;
      end else if (pre_r) begin
        pre_nxt = 1'b0;
      end else if (sub_r == sub_end) begin
        sub_nxt = '0;
        bit_nxt = bit_r + 1'b1;
      end else begin
        sub_nxt = sub_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cmd_r  <= CMD_START;
      sub_r  <= '0;
      bit_r  <= '0;
      pre_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cmd_r  <= cmd_nxt;
      sub_r  <= sub_nxt;
      bit_r  <= bit_nxt;
      pre_r  <= pre_nxt;
    end
  end

  assign busy = busy_r;

endmodule

### design/i2cms_shifter.sv
// Bit-serial data path: transmit shift register, sampled-line shift register
// and receive shift register. Depends on i2cms_pkg.
module i2cms_shifter (
  input  logic              clk,
  input  logic              load,
  input  i2cms_pkg::cmd_t   cmd_in,
  input  i2cms_pkg::byte_t  data_byte,
  input  logic              ack_value,
  input  i2cms_pkg::byte_t  bus_bits,
  input  logic              tx_shift,
  input  logic              rx_shift,
  output logic              tx_bit,
  output i2cms_pkg::byte_t  rx_byte
);
  import i2cms_pkg::*;

  byte_t tx_r, tx_nxt;
  byte_t bus_r, bus_nxt;
  byte_t rx_r, rx_nxt;

  always_comb begin
    tx_nxt  = tx_r;
    bus_nxt = bus_r;
    rx_nxt  = rx_r;
    if (load) begin
      tx_nxt  = (cmd_in == CMD_WACK) ? {ack_value, {(BITS_PER_BYTE-1){1'b0}}} : data_byte;
      bus_nxt = bus_bits;
      rx_nxt  = '0;
    end else begin
      if (tx_shift) begin
        tx_nxt = {tx_r[BITS_PER_BYTE-2:0], 1'b0};
      end
      if (rx_shift) begin
        rx_nxt  = {rx_r[BITS_PER_BYTE-2:0], bus_r[BITS_PER_BYTE-1]};
        bus_nxt = {bus_r[BITS_PER_BYTE-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    tx_r  <= tx_nxt;
    bus_r <= bus_nxt;
    rx_r  <= rx_nxt;
  end

  assign tx_bit  = tx_r[BITS_PER_BYTE-1];
  assign rx_byte = rx_r;

endmodule

### design/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: one command item in, a run of bus phase items out.
// An accepted command is registered in the sequencer, then each phase in the output register.
// Throughput: one phase per cycle while out is ready; each command is first loaded, and no
// phase is produced while it loads.
// The next command is taken once the last phase is in the output register.
// Reset: synchronous active-low; SCL and SDA levels return to 1 (released).
module i2c_master_bit_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  i2cms_cmd_if.sink   in_item,
  i2cms_phase_if.source out_item
);
  import i2cms_pkg::*;

  logic   busy;
  logic   load;
  logic   step;
  phase_t phase;
  logic   tx_bit;
  byte_t  rx_byte;

  logic   scl_r, scl_nxt;
  logic   sda_r, sda_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_scl_r, out_sda_r, out_ack_r, out_last_r;
  byte_t  out_byte_r;

  assign in_item.ready = rst_n && !busy;
  assign load = in_item.valid && rst_n && !busy;
  assign step = busy && (!out_valid_r || out_item.ready);

  i2cms_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .cmd_in (in_item.command),
    .step   (step),
    .busy   (busy),
    .phase  (phase)
  );

  i2cms_shifter u_shifter (
    .clk       (clk),
    .load      (load),
    .cmd_in    (in_item.command),
    .data_byte (in_item.data_byte),
    .ack_value (in_item.ack_value),
    .bus_bits  (in_item.bus_bits),
    .tx_shift  (step && phase.tx_shift),
    .rx_shift  (step && phase.rx_shift),
    .tx_bit    (tx_bit),
    .rx_byte   (rx_byte)
  );

  always_comb begin
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    unique case (phase.act)
      ACT_SDA0:   sda_nxt = 1'b0;
      ACT_SDA1:   sda_nxt = 1'b1;
      ACT_SDA_TX: sda_nxt = tx_bit;
      ACT_SCL0:   scl_nxt = 1'b0;
      ACT_SCL1:   scl_nxt = 1'b1;
      default:    ;
    endcase
    out_valid_nxt = step ? 1'b1 : (out_item.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        scl_r <= scl_nxt;
        sda_r <= sda_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_scl_r  <= scl_nxt;
      out_sda_r  <= sda_nxt;
      out_byte_r <= phase.rd_byte ? rx_byte : '0;
      out_ack_r  <= phase.rd_ack ? rx_byte[0] : 1'b0;
      out_last_r <= phase.last;
    end
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.scl       = out_scl_r;
  assign out_item.sda       = out_sda_r;
  assign out_item.read_byte = out_byte_r;
  assign out_item.ack_seen  = out_ack_r;
  assign out_item.last      = out_last_r;

endmodule
